@@ rtl/core/tncc_pkg.sv @@
package tncc_pkg;

  localparam int POS_W_DEF = 24;

  localparam int RAW_W  = 52;
  localparam int CCD_W  = 53;
  localparam int INV_W  = 32;
  localparam int UNIT_W = 32;

  localparam int NUM_EDGE = 4;
  localparam int NUM_AXIS = 3;

  localparam int HALF_W     = 26;
  localparam int SS_W       = 108;
  localparam int ROOT_W     = 54;
  localparam int RREM_W     = 58;
  localparam int DNUM_W     = 82;
  localparam int DREM_W     = 56;
  localparam int QUO_W      = 49;
  localparam int UNIT_SHIFT = 30;
  localparam int RECIP_BIT  = 48;
  localparam int CNT_W      = 7;

  localparam int QDEPTH = 2;

  localparam logic [1:0] CORNER_0 = 2'd0;
  localparam logic [1:0] CORNER_1 = 2'd1;
  localparam logic [1:0] CORNER_2 = 2'd2;

  // edge slots in a job word
  localparam logic [1:0] EDGE_E0 = 2'd0;
  localparam logic [1:0] EDGE_E2 = 2'd1;
  localparam logic [1:0] EDGE_E3 = 2'd2;
  localparam logic [1:0] EDGE_E4 = 2'd3;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

@@ rtl/core/triangle_normal_with_ccd_cross_core.sv @@
// corner 0 and 1 items take one cycle each while the job queue is not full; a corner 2
// item runs in the back end through cross-product, sum-of-squares, square-root and
// divide steps, one after another on the one shared multiplier and the bit-serial
// root/divide logic; the divide is skipped when the normal length is zero. a two-entry
// job queue lets corners keep arriving meanwhile. sync active-low reset clears stored
// corners to zero and empties the job queue and the result register
module triangle_normal_with_ccd_cross_core import tncc_pkg::*; #(
  parameter int POS_WIDTH = POS_W_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  output logic                        in_full,
  input  logic [1:0]                  in_corner,
  input  logic signed [POS_WIDTH-1:0] in_pos_x,
  input  logic signed [POS_WIDTH-1:0] in_pos_y,
  input  logic signed [POS_WIDTH-1:0] in_pos_z,
  input  logic signed [POS_WIDTH-1:0] in_render_x,
  input  logic signed [POS_WIDTH-1:0] in_render_y,
  input  logic signed [POS_WIDTH-1:0] in_render_z,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic signed [RAW_W-1:0]     out_raw_nx,
  output logic signed [RAW_W-1:0]     out_raw_ny,
  output logic signed [RAW_W-1:0]     out_raw_nz,
  output logic [INV_W-1:0]            out_inv_magnitude,
  output logic signed [UNIT_W-1:0]    out_unit_nx,
  output logic signed [UNIT_W-1:0]    out_unit_ny,
  output logic signed [UNIT_W-1:0]    out_unit_nz,
  output logic signed [CCD_W-1:0]     out_ccd_x,
  output logic signed [CCD_W-1:0]     out_ccd_y,
  output logic signed [CCD_W-1:0]     out_ccd_z,
  output logic                        out_degenerate
);

  localparam int JOB_W = NUM_EDGE * NUM_AXIS * (POS_WIDTH + 1);

  qstat_t           q_stat;
  logic             q_push;
  logic             q_pop;
  logic [JOB_W-1:0] q_din;
  logic [JOB_W-1:0] q_dout;

  tncc_front #(.POS_WIDTH(POS_WIDTH)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_corner  (in_corner),
    .in_pos_x   (in_pos_x),
    .in_pos_y   (in_pos_y),
    .in_pos_z   (in_pos_z),
    .in_render_x(in_render_x),
    .in_render_y(in_render_y),
    .in_render_z(in_render_z),
    .q_stat     (q_stat),
    .q_push     (q_push),
    .q_job      (q_din)
  );

  tncc_queue #(.WIDTH(JOB_W)) u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .din  (q_din),
    .pop  (q_pop),
    .dout (q_dout),
    .stat (q_stat)
  );

  tncc_back #(.POS_WIDTH(POS_WIDTH)) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_stat           (q_stat),
    .q_job            (q_dout),
    .q_pop            (q_pop),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_raw_nx       (out_raw_nx),
    .out_raw_ny       (out_raw_ny),
    .out_raw_nz       (out_raw_nz),
    .out_inv_magnitude(out_inv_magnitude),
    .out_unit_nx      (out_unit_nx),
    .out_unit_ny      (out_unit_ny),
    .out_unit_nz      (out_unit_nz),
    .out_ccd_x        (out_ccd_x),
    .out_ccd_y        (out_ccd_y),
    .out_ccd_z        (out_ccd_z),
    .out_degenerate   (out_degenerate)
  );

endmodule

@@ rtl/core/tncc_front.sv @@
module tncc_front import tncc_pkg::*; #(
  parameter int POS_WIDTH = POS_W_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       in_push,
  output logic                                       in_full,
  input  logic [1:0]                                 in_corner,
  input  logic signed [POS_WIDTH-1:0]                in_pos_x,
  input  logic signed [POS_WIDTH-1:0]                in_pos_y,
  input  logic signed [POS_WIDTH-1:0]                in_pos_z,
  input  logic signed [POS_WIDTH-1:0]                in_render_x,
  input  logic signed [POS_WIDTH-1:0]                in_render_y,
  input  logic signed [POS_WIDTH-1:0]                in_render_z,
  input  qstat_t                                     q_stat,
  output logic                                       q_push,
  output logic [NUM_EDGE*NUM_AXIS*(POS_WIDTH+1)-1:0] q_job
);

  localparam int EW = POS_WIDTH + 1;

  logic signed [POS_WIDTH-1:0] c0p_r [NUM_AXIS];
  logic signed [POS_WIDTH-1:0] c1p_r [NUM_AXIS];
  logic signed [POS_WIDTH-1:0] c0r_r [NUM_AXIS];
  logic signed [POS_WIDTH-1:0] c1r_r [NUM_AXIS];
  logic signed [POS_WIDTH-1:0] p [NUM_AXIS];
  logic signed [POS_WIDTH-1:0] r [NUM_AXIS];
  logic signed [EW-1:0]        ed [NUM_EDGE][NUM_AXIS];
  logic                        accept;

  assign in_full = q_stat.full;
  assign accept  = in_push && !q_stat.full;
  assign q_push  = accept && (in_corner == CORNER_2);

  always_comb begin
    p[0] = in_pos_x;
    p[1] = in_pos_y;
    p[2] = in_pos_z;
    r[0] = in_render_x;
    r[1] = in_render_y;
    r[2] = in_render_z;
    for (int c = 0; c < NUM_AXIS; c++) begin
      ed[EDGE_E0][c] = EW'(p[c]) - EW'(c0p_r[c]);
      ed[EDGE_E2][c] = EW'(c1p_r[c]) - EW'(c0p_r[c]);
      ed[EDGE_E3][c] = EW'(c1r_r[c]) - EW'(c0r_r[c]);
      ed[EDGE_E4][c] = EW'(r[c]) - EW'(c0r_r[c]);
    end
    for (int v = 0; v < NUM_EDGE; v++) begin
      for (int c = 0; c < NUM_AXIS; c++) begin
        q_job[(v*NUM_AXIS+c)*EW +: EW] = ed[v][c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NUM_AXIS; c++) begin
        c0p_r[c] <= '0;
        c1p_r[c] <= '0;
        c0r_r[c] <= '0;
        c1r_r[c] <= '0;
      end
    end else if (accept) begin
      for (int c = 0; c < NUM_AXIS; c++) begin
        if (in_corner == CORNER_0) begin
          c0p_r[c] <= p[c];
          c0r_r[c] <= r[c];
        end
        if (in_corner == CORNER_1) begin
          c1p_r[c] <= p[c];
          c1r_r[c] <= r[c];
        end
      end
    end
  end

endmodule

@@ rtl/core/tncc_queue.sv @@
module tncc_queue import tncc_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output qstat_t           stat
);

  localparam int PTR_W = $clog2(QDEPTH);
  localparam int CNT_QW = $clog2(QDEPTH + 1);

  logic [WIDTH-1:0]  mem_r [QDEPTH];
  logic [PTR_W-1:0]  wptr_r;
  logic [PTR_W-1:0]  rptr_r;
  logic [CNT_QW-1:0] cnt_r;

  assign stat.full  = (cnt_r == CNT_QW'(QDEPTH));
  assign stat.empty = (cnt_r == '0);
  assign dout       = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + PTR_W'(1);
      end
      if (pop) begin
        rptr_r <= rptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CNT_QW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CNT_QW'(1);
      end
    end
  end

endmodule

@@ rtl/core/tncc_back.sv @@
module tncc_back import tncc_pkg::*; #(
  parameter int POS_WIDTH = POS_W_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  qstat_t                                     q_stat,
  input  logic [NUM_EDGE*NUM_AXIS*(POS_WIDTH+1)-1:0] q_job,
  output logic                                       q_pop,
  output logic                                       out_empty,
  input  logic                                       out_pop,
  output logic signed [RAW_W-1:0]                    out_raw_nx,
  output logic signed [RAW_W-1:0]                    out_raw_ny,
  output logic signed [RAW_W-1:0]                    out_raw_nz,
  output logic [INV_W-1:0]                           out_inv_magnitude,
  output logic signed [UNIT_W-1:0]                   out_unit_nx,
  output logic signed [UNIT_W-1:0]                   out_unit_ny,
  output logic signed [UNIT_W-1:0]                   out_unit_nz,
  output logic signed [CCD_W-1:0]                    out_ccd_x,
  output logic signed [CCD_W-1:0]                    out_ccd_y,
  output logic signed [CCD_W-1:0]                    out_ccd_z,
  output logic                                       out_degenerate
);

  localparam int EW    = POS_WIDTH + 1;
  localparam int JOB_W = NUM_EDGE * NUM_AXIS * EW;
  localparam int MW    = (EW > HALF_W + 1) ? EW : HALF_W + 1;
  localparam int PW2   = 2 * MW;
  localparam int ACC_W = (2 * EW + 2 > CCD_W + 1) ? 2 * EW + 2 : CCD_W + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_XMUL = 3'd1;
  localparam logic [2:0] S_XACC = 3'd2;
  localparam logic [2:0] S_SMUL = 3'd3;
  localparam logic [2:0] S_SACC = 3'd4;
  localparam logic [2:0] S_ROOT = 3'd5;
  localparam logic [2:0] S_DIV  = 3'd6;
  localparam logic [2:0] S_PUSH = 3'd7;

  function automatic logic signed [RAW_W-1:0] sat_raw(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = $signed({{(ACC_W-RAW_W+1){1'b0}}, {(RAW_W-1){1'b1}}});
    lo = $signed({{(ACC_W-RAW_W+1){1'b1}}, {(RAW_W-1){1'b0}}});
    if (a > hi) begin
      return hi[RAW_W-1:0];
    end else if (a < lo) begin
      return lo[RAW_W-1:0];
    end
    return a[RAW_W-1:0];
  endfunction

  function automatic logic signed [CCD_W-1:0] sat_ccd(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = $signed({{(ACC_W-CCD_W+1){1'b0}}, {(CCD_W-1){1'b1}}});
    lo = $signed({{(ACC_W-CCD_W+1){1'b1}}, {(CCD_W-1){1'b0}}});
    if (a > hi) begin
      return hi[CCD_W-1:0];
    end else if (a < lo) begin
      return lo[CCD_W-1:0];
    end
    return a[CCD_W-1:0];
  endfunction

  logic [2:0]               state_r;
  logic                     out_valid_r;
  logic [JOB_W-1:0]         job_r;
  logic [1:0]               k_r;
  logic [2:0]               t_r;
  logic [CNT_W-1:0]         cnt_r;
  logic signed [PW2-1:0]    prod_r;
  logic signed [ACC_W-1:0]  acc_raw_r;
  logic signed [ACC_W-1:0]  acc_ccd_r;
  logic signed [RAW_W-1:0]  raw_r [NUM_AXIS];
  logic signed [CCD_W-1:0]  ccd_r [NUM_AXIS];
  logic [SS_W-1:0]          ss_r;
  logic [ROOT_W-1:0]        root_r;
  logic [RREM_W-1:0]        rrem_r;
  logic [DNUM_W-1:0]        num_r;
  logic [DREM_W-1:0]        drem_r;
  logic [QUO_W-1:0]         quo_r;
  logic [INV_W-1:0]         inv_r;
  logic signed [UNIT_W-1:0] unit_r [NUM_AXIS];
  logic                     degen_r;

  logic signed [EW-1:0]     ed [NUM_EDGE][NUM_AXIS];
  logic [1:0]               ax_i;
  logic [1:0]               ax_j;
  logic [1:0]               a_v;
  logic [1:0]               a_c;
  logic [1:0]               b_v;
  logic [1:0]               b_c;
  logic [1:0]               km1;
  logic signed [RAW_W-1:0]  raw_sel;
  logic signed [RAW_W-1:0]  raw_div;
  logic [RAW_W-1:0]         mag_sel;
  logic [HALF_W-1:0]        mag_hi;
  logic [HALF_W-1:0]        mag_lo;
  logic signed [MW-1:0]     mul_a;
  logic signed [MW-1:0]     mul_b;
  logic signed [ACC_W-1:0]  term;
  logic signed [ACC_W-1:0]  acc_raw_nxt;
  logic signed [ACC_W-1:0]  acc_ccd_nxt;
  logic [SS_W-1:0]          sq_term;
  logic [RREM_W-1:0]        rrem2;
  logic [RREM_W-1:0]        trial;
  logic [RREM_W-1:0]        rrem_nxt;
  logic [ROOT_W-1:0]        root_nxt;
  logic [DREM_W-1:0]        drem2;
  logic [DREM_W-1:0]        dvs;
  logic [DREM_W-1:0]        drem_nxt;
  logic [QUO_W-1:0]         quo_nxt;
  logic [UNIT_W-1:0]        q_unit;
  logic                     push_ok;

  assign q_pop     = (state_r == S_IDLE) && !q_stat.empty;
  assign out_empty = !out_valid_r;
  assign push_ok   = (state_r == S_PUSH) && (!out_valid_r || out_pop);
  assign km1       = k_r - 2'd1;

  always_comb begin
    for (int v = 0; v < NUM_EDGE; v++) begin
      for (int c = 0; c < NUM_AXIS; c++) begin
        ed[v][c] = job_r[(v*NUM_AXIS+c)*EW +: EW];
      end
    end

    case (k_r)
      2'd0: begin
        ax_i = 2'd1; ax_j = 2'd2; raw_sel = raw_r[0];
      end
      2'd1: begin
        ax_i = 2'd2; ax_j = 2'd0; raw_sel = raw_r[1];
      end
      2'd2: begin
        ax_i = 2'd0; ax_j = 2'd1; raw_sel = raw_r[2];
      end
      default: begin
        ax_i = 2'd1; ax_j = 2'd2; raw_sel = raw_r[0];
      end
    endcase

    case (km1)
      2'd1:    raw_div = raw_r[1];
      2'd2:    raw_div = raw_r[2];
      default: raw_div = raw_r[0];
    endcase

    mag_sel = raw_sel[RAW_W-1] ? RAW_W'(-raw_sel) : raw_sel;
    mag_hi  = mag_sel[RAW_W-1 -: HALF_W];
    mag_lo  = mag_sel[HALF_W-1:0];

    // cross terms: raw e2xe0, ccd e3xe0 + e2xe4
    a_v = (t_r inside {3'd2, 3'd3}) ? EDGE_E3 : EDGE_E2;
    a_c = t_r[0] ? ax_j : ax_i;
    b_v = (t_r < 3'd4) ? EDGE_E0 : EDGE_E4;
    b_c = t_r[0] ? ax_i : ax_j;

    if (state_r == S_SMUL) begin
      case (t_r)
        3'd0: begin
          mul_a = $signed(MW'(mag_hi)); mul_b = $signed(MW'(mag_hi));
        end
        3'd1: begin
          mul_a = $signed(MW'(mag_hi)); mul_b = $signed(MW'(mag_lo));
        end
        default: begin
          mul_a = $signed(MW'(mag_lo)); mul_b = $signed(MW'(mag_lo));
        end
      endcase
    end else begin
      mul_a = MW'(ed[a_v][a_c]);
      mul_b = MW'(ed[b_v][b_c]);
    end

    term        = ACC_W'(prod_r);
    acc_raw_nxt = acc_raw_r;
    acc_ccd_nxt = acc_ccd_r;
    if (t_r < 3'd2) begin
      acc_raw_nxt = t_r[0] ? acc_raw_r - term : acc_raw_r + term;
    end else begin
      acc_ccd_nxt = t_r[0] ? acc_ccd_r - term : acc_ccd_r + term;
    end

    case (t_r)
      3'd0:    sq_term = SS_W'($unsigned(prod_r)) << (2 * HALF_W);
      3'd1:    sq_term = SS_W'($unsigned(prod_r)) << (HALF_W + 1);
      default: sq_term = SS_W'($unsigned(prod_r));
    endcase

    rrem2 = {rrem_r[RREM_W-3:0], ss_r[SS_W-1 -: 2]};
    trial = RREM_W'({root_r, 2'b01});
    if (rrem2 >= trial) begin
      rrem_nxt = rrem2 - trial;
      root_nxt = {root_r[ROOT_W-2:0], 1'b1};
    end else begin
      rrem_nxt = rrem2;
      root_nxt = {root_r[ROOT_W-2:0], 1'b0};
    end

    drem2 = {drem_r[DREM_W-2:0], num_r[DNUM_W-1]};
    dvs   = DREM_W'(root_r);
    if (drem2 >= dvs) begin
      drem_nxt = drem2 - dvs;
      quo_nxt  = {quo_r[QUO_W-2:0], 1'b1};
    end else begin
      drem_nxt = drem2;
      quo_nxt  = {quo_r[QUO_W-2:0], 1'b0};
    end
    q_unit = raw_div[RAW_W-1] ? -quo_nxt[UNIT_W-1:0] : quo_nxt[UNIT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (push_ok) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (!q_stat.empty) begin
            state_r <= S_XMUL;
          end
        end
        S_XMUL: state_r <= S_XACC;
        S_XACC: begin
          if (t_r == 3'd5 && k_r == 2'd2) begin
            state_r <= S_SMUL;
          end else begin
            state_r <= S_XMUL;
          end
        end
        S_SMUL: state_r <= S_SACC;
        S_SACC: begin
          if (t_r == 3'd2 && k_r == 2'd2) begin
            state_r <= S_ROOT;
          end else begin
            state_r <= S_SMUL;
          end
        end
        S_ROOT: begin
          if (cnt_r == CNT_W'(ROOT_W - 1)) begin
            state_r <= (root_nxt == '0) ? S_PUSH : S_DIV;
          end
        end
        S_DIV: begin
          if (cnt_r == CNT_W'(DNUM_W - 1) && k_r == 2'd3) begin
            state_r <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (push_ok) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (!q_stat.empty) begin
          job_r     <= q_job;
          k_r       <= 2'd0;
          t_r       <= 3'd0;
          acc_raw_r <= '0;
          acc_ccd_r <= '0;
        end
      end
      S_XMUL, S_SMUL: begin
        prod_r <= mul_a * mul_b;
      end
      S_XACC: begin
        if (t_r == 3'd5) begin
          raw_r[k_r] <= sat_raw(acc_raw_r);
          ccd_r[k_r] <= sat_ccd(acc_ccd_nxt);
          acc_raw_r  <= '0;
          acc_ccd_r  <= '0;
          t_r        <= 3'd0;
          if (k_r == 2'd2) begin
            k_r  <= 2'd0;
            ss_r <= '0;
          end else begin
            k_r <= k_r + 2'd1;
          end
        end else begin
          acc_raw_r <= acc_raw_nxt;
          acc_ccd_r <= acc_ccd_nxt;
          t_r       <= t_r + 3'd1;
        end
      end
      S_SACC: begin
        ss_r <= ss_r + sq_term;
        if (t_r == 3'd2) begin
          t_r <= 3'd0;
          if (k_r == 2'd2) begin
            cnt_r  <= '0;
            root_r <= '0;
            rrem_r <= '0;
          end else begin
            k_r <= k_r + 2'd1;
          end
        end else begin
          t_r <= t_r + 3'd1;
        end
      end
      S_ROOT: begin
        ss_r   <= ss_r << 2;
        root_r <= root_nxt;
        rrem_r <= rrem_nxt;
        if (cnt_r == CNT_W'(ROOT_W - 1)) begin
          cnt_r  <= '0;
          k_r    <= 2'd0;
          num_r  <= DNUM_W'(1) << RECIP_BIT;
          drem_r <= '0;
          quo_r  <= '0;
          if (root_nxt == '0) begin
            inv_r   <= '1;
            degen_r <= 1'b1;
            for (int c = 0; c < NUM_AXIS; c++) begin
              unit_r[c] <= '0;
            end
          end
        end else begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
      end
      S_DIV: begin
        if (cnt_r == CNT_W'(DNUM_W - 1)) begin
          cnt_r  <= '0;
          drem_r <= '0;
          quo_r  <= '0;
          num_r  <= DNUM_W'(mag_sel) << UNIT_SHIFT;
          k_r    <= k_r + 2'd1;
          if (k_r == 2'd0) begin
            inv_r <= (|quo_nxt[QUO_W-1:INV_W]) ? '1 : quo_nxt[INV_W-1:0];
          end else begin
            unit_r[km1] <= q_unit;
          end
          if (k_r == 2'd3) begin
            degen_r <= 1'b0;
          end
        end else begin
          num_r  <= num_r << 1;
          drem_r <= drem_nxt;
          quo_r  <= quo_nxt;
          cnt_r  <= cnt_r + CNT_W'(1);
        end
      end
      S_PUSH: begin
        if (push_ok) begin
          out_raw_nx        <= raw_r[0];
          out_raw_ny        <= raw_r[1];
          out_raw_nz        <= raw_r[2];
          out_inv_magnitude <= inv_r;
          out_unit_nx       <= unit_r[0];
          out_unit_ny       <= unit_r[1];
          out_unit_nz       <= unit_r[2];
          out_ccd_x         <= ccd_r[0];
          out_ccd_y         <= ccd_r[1];
          out_ccd_z         <= ccd_r[2];
          out_degenerate    <= degen_r;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
